FILE: hw/rtl/mesc_pkg.sv
package mesc_pkg;

   // widths fixed by the register map and the word fields
   localparam int SAMPLE_W    = 16;
   localparam int SEL_W       = 20;
   localparam int FLUSH_W     = 8;
   localparam int COUNT_W     = 16;
   localparam int IDX_W       = 3;
   localparam int CSR_INDEX_W = 2;

   // defaults for the top level parameters
   localparam int NUM_ENCODERS_DEF = 5;
   localparam int PORT_COUNT_DEF   = 2;

   // at most this many result words per sample
   localparam int MAX_RESULTS = 10;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [FLUSH_W-1:0] FLUSH_RESET = 8'd200;
   localparam logic [FLUSH_W-1:0] IDLE_MAX    = 8'd255;

   typedef logic signed [COUNT_W-1:0] count_type;

   localparam count_type COUNT_MAX = 16'sh7fff;
   localparam count_type COUNT_MIN = 16'sh8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_A_SEL  = 2'd0,
      CSR_B_SEL  = 2'd1,
      CSR_SW_SEL = 2'd2,
      CSR_FLUSH  = 2'd3
   } csr_index_type;

   localparam logic EVT_SWITCH   = 1'b0;
   localparam logic EVT_ROTATION = 1'b1;

   // 4-bit sample bit index of one encoder's pin; past the register it reads 0
   function automatic logic [3:0] pin_index(input logic [SEL_W-1:0] sel, input int enc);
      logic [3:0] idx;
      idx = '0;
      if (enc < SEL_W / 4) begin
         idx = sel[enc*4 +: 4];
      end
      return idx;
   endfunction

endpackage

FILE: hw/rtl/mesc_count_mem.sv
module mesc_count_mem
   import mesc_pkg::*;
#(
   parameter int DEPTH  = NUM_ENCODERS_DEF,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output count_type         rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  count_type         wr_data
);

   count_type          cnt_mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   count_type          rd_q_ff;
   logic               rd_vld_ff;

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff   <= cnt_mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

FILE: hw/rtl/mesc_pin_map.sv
module mesc_pin_map
   import mesc_pkg::*;
#(
   parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
) (
   input  logic [SAMPLE_W-1:0]     sample,
   input  logic [SAMPLE_W-1:0]     prev_sample,
   input  logic [SEL_W-1:0]        a_sel,
   input  logic [SEL_W-1:0]        b_sel,
   input  logic [SEL_W-1:0]        sw_sel,
   output logic [NUM_ENCODERS-1:0] b_chg,
   output logic [NUM_ENCODERS-1:0] a_lvl,
   output logic [NUM_ENCODERS-1:0] sw_chg,
   output logic [NUM_ENCODERS-1:0] sw_lvl
);

   logic [SAMPLE_W-1:0] changed;

   assign changed = sample ^ prev_sample;

   // every encoder picks its own pins, shared pins included
   always_comb begin
      for (int e = 0; e < NUM_ENCODERS; e++) begin
         b_chg[e]  = changed[pin_index(b_sel, e)];
         a_lvl[e]  = sample[pin_index(a_sel, e)];
         sw_chg[e] = changed[pin_index(sw_sel, e)];
         sw_lvl[e] = sample[pin_index(sw_sel, e)];
      end
   end

endmodule

FILE: hw/rtl/multi_encoder_scanner.sv
// channel   dir  handshake             payload
// req       in   req_valid/req_stall   req_pin_sample
// rsp       out  rsp_valid/rsp_stall   rsp_event_kind, rsp_encoder_index, rsp_switch_level,
//                                      rsp_rotation_count, rsp_last_event
// csr       in   csr_write             csr_index, csr_data
//
// one sample at a time; the first sample after reset only primes the previous sample
// a later sample is accepted, then every encoder count gets a read-modify-write, then the
// switch words go out (a decision step when there are none), then each flushed count is
// read, sent and cleared
// reset is synchronous and active high; counts start at zero through the memory valid bits
// a stalled rsp word holds in the output register; req_stall is high while a sample is at work
module multi_encoder_scanner
   import mesc_pkg::*;
#(
   parameter int NUM_ENCODERS = NUM_ENCODERS_DEF,
   parameter int PORT_COUNT   = PORT_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_W-1:0]    req_pin_sample,
   // event channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_event_kind,
   output logic [IDX_W-1:0]       rsp_encoder_index,
   output logic                   rsp_switch_level,
   output logic signed [COUNT_W-1:0] rsp_rotation_count,
   output logic                   rsp_last_event,
   // register writes
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SEL_W-1:0]       csr_data
);

   localparam int ENC_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
   localparam logic [SAMPLE_W-1:0] PORT_MASK = SAMPLE_W'((32'd1 << (8 * PORT_COUNT)) - 32'd1);
   localparam logic [ENC_W-1:0] LAST_ENC = ENC_W'(NUM_ENCODERS - 1);
   localparam logic [RES_CNT_W-1:0] RES_LAST = RES_CNT_W'(MAX_RESULTS - 1);
   localparam logic [RES_CNT_W-1:0] RES_FULL = RES_CNT_W'(MAX_RESULTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SWITCH,
      ST_FL_READ,
      ST_FL_EMIT
   } state_type;

   // control and configuration
   state_type                 state_ff, state_in;
   logic [SEL_W-1:0]          a_sel_ff, a_sel_in;
   logic [SEL_W-1:0]          b_sel_ff, b_sel_in;
   logic [SEL_W-1:0]          sw_sel_ff, sw_sel_in;
   logic [FLUSH_W-1:0]        flush_ff, flush_in;
   logic [SAMPLE_W-1:0]       prev_ff, prev_in;
   logic                      primed_ff, primed_in;
   logic [FLUSH_W-1:0]        idle_ff, idle_in;
   // per-sample work
   logic [ENC_W-1:0]          enc_ff, enc_in;
   logic                      rd_more_ff, rd_more_in;
   logic                      wb_pend_ff, wb_pend_in;
   logic [ENC_W-1:0]          wb_enc_ff, wb_enc_in;
   logic [ENC_W-1:0]          fl_enc_ff, fl_enc_in;
   logic [NUM_ENCODERS-1:0]   b_chg_ff, b_chg_in;
   logic [NUM_ENCODERS-1:0]   a_lvl_ff, a_lvl_in;
   logic [NUM_ENCODERS-1:0]   sw_pend_ff, sw_pend_in;
   logic [NUM_ENCODERS-1:0]   sw_lvl_ff, sw_lvl_in;
   logic [NUM_ENCODERS-1:0]   rot_pend_ff, rot_pend_in;
   logic                      rot_any_ff, rot_any_in;
   logic                      do_flush_ff, do_flush_in;
   logic [RES_CNT_W-1:0]      n_cnt_ff, n_cnt_in;
   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]          rsp_idx_ff, rsp_idx_in;
   logic                      rsp_lvl_ff, rsp_lvl_in;
   count_type                 rsp_cnt_ff, rsp_cnt_in;
   logic                      rsp_last_ff, rsp_last_in;

   // pin decode of the incoming word
   logic [SAMPLE_W-1:0]       sample;
   logic [NUM_ENCODERS-1:0]   map_b_chg, map_a_lvl, map_sw_chg, map_sw_lvl;

   // count memory port
   logic                      mem_rd_en;
   logic [ENC_W-1:0]          mem_rd_addr;
   count_type                 mem_rd_data;
   logic                      mem_wr_en;
   logic [ENC_W-1:0]          mem_wr_addr;
   count_type                 mem_wr_data;

   // helpers
   logic                      slot_free;
   count_type                 upd_cnt;
   logic [ENC_W-1:0]          sw_low, rot_low;
   logic [NUM_ENCODERS-1:0]   sw_rest, rot_rest;
   logic [FLUSH_W-1:0]        idle_base, idle_next;
   logic                      rot_left;

   assign sample = req_pin_sample & PORT_MASK;

   mesc_pin_map #(
      .NUM_ENCODERS (NUM_ENCODERS)
   ) u_pin_map (
      .sample      (sample),
      .prev_sample (prev_ff),
      .a_sel       (a_sel_ff),
      .b_sel       (b_sel_ff),
      .sw_sel      (sw_sel_ff),
      .b_chg       (map_b_chg),
      .a_lvl       (map_a_lvl),
      .sw_chg      (map_sw_chg),
      .sw_lvl      (map_sw_lvl)
   );

   mesc_count_mem #(
      .DEPTH  (NUM_ENCODERS),
      .ADDR_W (ENC_W)
   ) u_count_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // lowest pending encoder of each kind
   always_comb begin
      sw_low  = '0;
      rot_low = '0;
      for (int i = NUM_ENCODERS - 1; i >= 0; i--) begin
         if (sw_pend_ff[i]) begin
            sw_low = ENC_W'(i);
         end
         if (rot_pend_ff[i]) begin
            rot_low = ENC_W'(i);
         end
      end
   end

   always_comb begin
      sw_rest          = sw_pend_ff;
      sw_rest[sw_low]  = 1'b0;
      rot_rest         = rot_pend_ff;
      rot_rest[fl_enc_ff] = 1'b0;
   end

   // saturating step of the entry read last cycle
   always_comb begin
      upd_cnt = mem_rd_data;
      if (b_chg_ff[wb_enc_ff]) begin
         if (!a_lvl_ff[wb_enc_ff]) begin
            if (mem_rd_data != COUNT_MAX) begin
               upd_cnt = mem_rd_data + 16'sd1;
            end
         end else begin
            if (mem_rd_data != COUNT_MIN) begin
               upd_cnt = mem_rd_data - 16'sd1;
            end
         end
      end
   end

   // idle tick counter: cleared by rotation, saturating
   always_comb begin
      idle_base = rot_any_ff ? '0 : idle_ff;
      idle_next = (idle_base == IDLE_MAX) ? IDLE_MAX : idle_base + 8'd1;
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rot_left  = do_flush_ff && (rot_pend_ff != '0);

   always_comb begin
      state_in     = state_ff;
      a_sel_in     = a_sel_ff;
      b_sel_in     = b_sel_ff;
      sw_sel_in    = sw_sel_ff;
      flush_in     = flush_ff;
      prev_in      = prev_ff;
      primed_in    = primed_ff;
      idle_in      = idle_ff;
      enc_in       = enc_ff;
      rd_more_in   = rd_more_ff;
      wb_pend_in   = 1'b0;
      wb_enc_in    = wb_enc_ff;
      fl_enc_in    = fl_enc_ff;
      b_chg_in     = b_chg_ff;
      a_lvl_in     = a_lvl_ff;
      sw_pend_in   = sw_pend_ff;
      sw_lvl_in    = sw_lvl_ff;
      rot_pend_in  = rot_pend_ff;
      rot_any_in   = rot_any_ff;
      do_flush_in  = do_flush_ff;
      n_cnt_in     = n_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = enc_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wb_enc_ff;
      mem_wr_data  = upd_cnt;

      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_A_SEL:  a_sel_in  = csr_data;
            CSR_B_SEL:  b_sel_in  = csr_data;
            CSR_SW_SEL: sw_sel_in = csr_data;
            CSR_FLUSH:  flush_in  = csr_data[FLUSH_W-1:0];
            default:    ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               prev_in = sample;
               if (primed_ff) begin
                  // latch pin decode, then sweep the count memory
                  b_chg_in    = map_b_chg;
                  a_lvl_in    = map_a_lvl;
                  sw_pend_in  = map_sw_chg;
                  sw_lvl_in   = map_sw_lvl;
                  rot_any_in  = |map_b_chg;
                  rot_pend_in = '0;
                  n_cnt_in    = '0;
                  enc_in      = '0;
                  rd_more_in  = 1'b1;
                  state_in    = ST_UPDATE;
               end else begin
                  primed_in = 1'b1;
               end
            end
         end

         ST_UPDATE: begin
            // read of entry k overlaps write-back of entry k - 1
            if (rd_more_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = enc_ff;
               wb_pend_in  = 1'b1;
               wb_enc_in   = enc_ff;
               if (enc_ff == LAST_ENC) begin
                  rd_more_in = 1'b0;
               end else begin
                  enc_in = enc_ff + 1'b1;
               end
            end
            if (wb_pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wb_enc_ff;
               mem_wr_data = upd_cnt;
               rot_pend_in[wb_enc_ff] = (upd_cnt != '0);
            end
            if (!rd_more_ff) begin
               // last write-back: settle the idle counter and the flush
               if (idle_next >= flush_ff) begin
                  do_flush_in = 1'b1;
                  idle_in     = '0;
               end else begin
                  do_flush_in = 1'b0;
                  idle_in     = idle_next;
               end
               state_in = ST_SWITCH;
            end
         end

         ST_SWITCH: begin
            if (sw_pend_ff == '0 || n_cnt_ff == RES_FULL) begin
               state_in = rot_left ? ST_FL_READ : ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = EVT_SWITCH;
               rsp_idx_in   = IDX_W'(sw_low);
               rsp_lvl_in   = sw_lvl_ff[sw_low];
               rsp_cnt_in   = '0;
               rsp_last_in  = ((sw_rest == '0) && !rot_left) || (n_cnt_ff == RES_LAST);
               n_cnt_in     = n_cnt_ff + 1'b1;
               sw_pend_in   = sw_rest;
               if (sw_rest == '0) begin
                  state_in = rot_left ? ST_FL_READ : ST_IDLE;
               end
            end
         end

         ST_FL_READ: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = rot_low;
            fl_enc_in   = rot_low;
            state_in    = ST_FL_EMIT;
         end

         ST_FL_EMIT: begin
            // counts past the word limit are cleared without a word
            if (n_cnt_ff == RES_FULL || slot_free) begin
               if (n_cnt_ff != RES_FULL) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = EVT_ROTATION;
                  rsp_idx_in   = IDX_W'(fl_enc_ff);
                  rsp_lvl_in   = 1'b0;
                  rsp_cnt_in   = mem_rd_data;
                  rsp_last_in  = (rot_rest == '0) || (n_cnt_ff == RES_LAST);
                  n_cnt_in     = n_cnt_ff + 1'b1;
               end
               mem_wr_en   = 1'b1;
               mem_wr_addr = fl_enc_ff;
               mem_wr_data = '0;
               rot_pend_in = rot_rest;
               state_in    = (rot_rest == '0) ? ST_IDLE : ST_FL_READ;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_sel_ff     <= '0;
         b_sel_ff     <= '0;
         sw_sel_ff    <= '0;
         flush_ff     <= FLUSH_RESET;
         prev_ff      <= '0;
         primed_ff    <= 1'b0;
         idle_ff      <= '0;
         rd_more_ff   <= 1'b0;
         wb_pend_ff   <= 1'b0;
         rot_pend_ff  <= '0;
         sw_pend_ff   <= '0;
         rot_any_ff   <= 1'b0;
         do_flush_ff  <= 1'b0;
         n_cnt_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_sel_ff     <= a_sel_in;
         b_sel_ff     <= b_sel_in;
         sw_sel_ff    <= sw_sel_in;
         flush_ff     <= flush_in;
         prev_ff      <= prev_in;
         primed_ff    <= primed_in;
         idle_ff      <= idle_in;
         rd_more_ff   <= rd_more_in;
         wb_pend_ff   <= wb_pend_in;
         rot_pend_ff  <= rot_pend_in;
         sw_pend_ff   <= sw_pend_in;
         rot_any_ff   <= rot_any_in;
         do_flush_ff  <= do_flush_in;
         n_cnt_ff     <= n_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      enc_ff      <= enc_in;
      wb_enc_ff   <= wb_enc_in;
      fl_enc_ff   <= fl_enc_in;
      b_chg_ff    <= b_chg_in;
      a_lvl_ff    <= a_lvl_in;
      sw_lvl_ff   <= sw_lvl_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_kind_ff;
   assign rsp_encoder_index  = rsp_idx_ff;
   assign rsp_switch_level   = rsp_lvl_ff;
   assign rsp_rotation_count = rsp_cnt_ff;
   assign rsp_last_event     = rsp_last_ff;

endmodule
